// ----- src/t16ex_pkg.sv -----
`timescale 1ns / 1ps

package t16ex_pkg;

  localparam int XLEN     = 32;
  localparam int RF_DEPTH = 15;
  localparam int RF_AW    = 4;

  localparam logic [3:0] PC_IDX = 4'd15;

  localparam logic [4:0] OP_LSL_IMM = 5'd0;
  localparam logic [4:0] OP_LSR_IMM = 5'd1;
  localparam logic [4:0] OP_ASR_IMM = 5'd2;
  localparam logic [4:0] OP_ADD_REG = 5'd3;
  localparam logic [4:0] OP_SUB_REG = 5'd4;
  localparam logic [4:0] OP_ADD_IMM = 5'd5;
  localparam logic [4:0] OP_SUB_IMM = 5'd6;
  localparam logic [4:0] OP_MOV_IMM = 5'd7;
  localparam logic [4:0] OP_CMP_IMM = 5'd8;
  localparam logic [4:0] OP_AND     = 5'd9;
  localparam logic [4:0] OP_EOR     = 5'd10;
  localparam logic [4:0] OP_LSL_REG = 5'd11;
  localparam logic [4:0] OP_LSR_REG = 5'd12;
  localparam logic [4:0] OP_ASR_REG = 5'd13;
  localparam logic [4:0] OP_ADC     = 5'd14;
  localparam logic [4:0] OP_SBC     = 5'd15;
  localparam logic [4:0] OP_ROR     = 5'd16;
  localparam logic [4:0] OP_TST     = 5'd17;
  localparam logic [4:0] OP_ADD_HI  = 5'd18;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDEF  = 2'd1;
  localparam logic [1:0] ST_UNPRED = 2'd2;

  typedef struct packed {
    logic            wrote;
    logic [3:0]      wreg;
    logic [XLEN-1:0] value;
    logic [3:0]      nzcv;
    logic [XLEN-1:0] next_addr;
    logic            eob;
    logic [1:0]      status;
  } t16ex_res_t;

endpackage

// ----- src/t16ex_ram.sv -----
`timescale 1ns / 1ps

module t16ex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- src/t16ex_alu.sv -----
`timescale 1ns / 1ps

module t16ex_alu
  import t16ex_pkg::*;
(
  input  logic [4:0]      op,
  input  logic [3:0]      dest_reg,
  input  logic [3:0]      second_reg,
  input  logic [7:0]      imm,
  input  logic [XLEN-1:0] addr,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic [3:0]      flags,
  output t16ex_res_t      res
);

  function automatic logic [XLEN:0] shift_fn(input logic [1:0] kind, input logic [XLEN-1:0] x,
                                             input logic [7:0] s, input logic cin);
    logic [XLEN:0]        t;
    logic signed [XLEN:0] ts;
    logic [2*XLEN-1:0]    w;
    logic                 big;
    logic                 is32;
    big  = (s > 8'd32);
    is32 = (s == 8'd32);
    shift_fn = {cin, x};
    if (s != 8'd0) begin
      case (kind)
        SH_LSL: begin
          t = {1'b0, x} << s[4:0];
          if (big) shift_fn = '0;
          else if (is32) shift_fn = {x[0], {XLEN{1'b0}}};
          else shift_fn = t;
        end
        SH_LSR: begin
          t = {x, 1'b0} >> s[4:0];
          if (big) shift_fn = '0;
          else if (is32) shift_fn = {x[XLEN-1], {XLEN{1'b0}}};
          else shift_fn = {t[0], t[XLEN:1]};
        end
        SH_ASR: begin
          ts = $signed({x, 1'b0}) >>> s[4:0];
          if (big || is32) shift_fn = {(XLEN+1){x[XLEN-1]}};
          else shift_fn = {ts[0], ts[XLEN:1]};
        end
        default: begin
          w = {x, x} >> s[4:0];
          shift_fn = {w[XLEN-1], w[XLEN-1:0]};
        end
      endcase
    end
  endfunction

  logic [XLEN-1:0] imm_x;
  logic [XLEN-1:0] ad_a;
  logic [XLEN-1:0] ad_b;
  logic            ad_cin;
  logic [XLEN:0]   sum;
  logic            add_v;
  logic [1:0]      sh_kind;
  logic [XLEN-1:0] sh_x;
  logic [7:0]      sh_s;
  logic [XLEN:0]   sh_out;
  logic [XLEN-1:0] value;
  logic            nc;
  logic            nv;
  logic            wr_low;
  logic            upd;

  assign imm_x = {{(XLEN-8){1'b0}}, imm};

  always_comb begin
    ad_a   = a;
    ad_b   = b;
    ad_cin = 1'b0;
    case (op)
      OP_SUB_REG: begin
        ad_b   = ~b;
        ad_cin = 1'b1;
      end
      OP_ADD_IMM: ad_b = imm_x;
      OP_SUB_IMM, OP_CMP_IMM: begin
        ad_b   = ~imm_x;
        ad_cin = 1'b1;
      end
      OP_ADC: ad_cin = flags[1];
      OP_SBC: begin
        ad_b   = ~b;
        ad_cin = flags[1];
      end
      default: ;
    endcase
  end

  assign sum   = {1'b0, ad_a} + {1'b0, ad_b} + {{XLEN{1'b0}}, ad_cin};
  assign add_v = (ad_a[XLEN-1] ^ sum[XLEN-1]) & (ad_b[XLEN-1] ^ sum[XLEN-1]);

  always_comb begin
    sh_kind = SH_ROR;
    sh_x    = a;
    sh_s    = b[7:0];
    case (op)
      OP_LSL_IMM: begin
        sh_kind = SH_LSL;
        sh_x    = b;
        sh_s    = {3'b000, imm[4:0]};
      end
      OP_LSR_IMM, OP_ASR_IMM: begin
        sh_kind = (op == OP_LSR_IMM) ? SH_LSR : SH_ASR;
        sh_x    = b;
        sh_s    = (imm[4:0] == 5'd0) ? 8'd32 : {3'b000, imm[4:0]};
      end
      OP_LSL_REG: sh_kind = SH_LSL;
      OP_LSR_REG: sh_kind = SH_LSR;
      OP_ASR_REG: sh_kind = SH_ASR;
      default: ;
    endcase
  end

  assign sh_out = shift_fn(sh_kind, sh_x, sh_s, flags[1]);

  always_comb begin
    value         = '0;
    nc            = flags[1];
    nv            = flags[0];
    wr_low        = 1'b1;
    upd           = 1'b1;
    res.wrote     = 1'b0;
    res.wreg      = 4'd0;
    res.next_addr = addr + XLEN'(2);
    res.eob       = 1'b0;
    res.status    = ST_OK;
    case (op)
      OP_LSL_IMM, OP_LSR_IMM, OP_ASR_IMM, OP_LSL_REG, OP_LSR_REG, OP_ASR_REG, OP_ROR: begin
        value = sh_out[XLEN-1:0];
        nc    = sh_out[XLEN];
      end
      OP_ADD_REG, OP_SUB_REG, OP_ADD_IMM, OP_SUB_IMM, OP_ADC, OP_SBC: begin
        value = sum[XLEN-1:0];
        nc    = sum[XLEN];
        nv    = add_v;
      end
      OP_CMP_IMM: begin
        value  = sum[XLEN-1:0];
        nc     = sum[XLEN];
        nv     = add_v;
        wr_low = 1'b0;
      end
      OP_MOV_IMM: value = imm_x;
      OP_AND:     value = a & b;
      OP_EOR:     value = a ^ b;
      OP_TST: begin
        value  = a & b;
        wr_low = 1'b0;
      end
      OP_ADD_HI: begin
        wr_low = 1'b0;
        upd    = 1'b0;
        if (dest_reg == PC_IDX && second_reg == PC_IDX) begin
          res.status = ST_UNPRED;
          res.eob    = 1'b1;
        end else begin
          value = sum[XLEN-1:0];
          if (dest_reg == PC_IDX) begin
            res.wreg      = PC_IDX;
            res.next_addr = {sum[XLEN-1:1], 1'b0};
            res.eob       = 1'b1;
          end else begin
            res.wrote = 1'b1;
            res.wreg  = dest_reg;
          end
        end
      end
      default: begin
        wr_low     = 1'b0;
        upd        = 1'b0;
        res.status = ST_UNDEF;
        res.eob    = 1'b1;
      end
    endcase
    if (wr_low) begin
      res.wrote = 1'b1;
      res.wreg  = {1'b0, dest_reg[2:0]};
    end
    res.value = value;
    res.nzcv  = upd ? {value[XLEN-1], (value == '0), nc, nv} : flags;
  end

endmodule

// ----- src/thumb16_alu_execute.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_ready     operation, register indexes, immediate, address
// out_     output     out_valid / out_ready   write info, value, flags, next address, status
//
// An item is accepted every cycle while the output is not stalled; the register file read
// is registered in the execute stage, the ALU result in the output register driving out_.
// Registers R0-R14 live in a two-read, one-write RAM; per-entry valid bits make
// untouched registers read as zero, and the write of the item ahead is forwarded.
// Reset clears the valid bits, the flags and both stage valids.
// A stalled output holds one item in the output register and one in the execute stage.

module thumb16_alu_execute
  import t16ex_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [4:0]      in_operation,
  input  logic [3:0]      in_dest_reg,
  input  logic [2:0]      in_first_reg,
  input  logic [3:0]      in_second_reg,
  input  logic [7:0]      in_immediate,
  input  logic [XLEN-1:0] in_instr_address,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_wrote_register,
  output logic [3:0]      out_written_register,
  output logic [XLEN-1:0] out_written_value,
  output logic [3:0]      out_flags_nzcv,
  output logic [XLEN-1:0] out_next_address,
  output logic            out_end_of_block,
  output logic [1:0]      out_status
);

  logic             accept;
  logic             s1_adv;
  logic             s1_valid_r;
  logic [4:0]       s1_op_r;
  logic [3:0]       s1_dest_r;
  logic [3:0]       s1_second_r;
  logic [7:0]       s1_imm_r;
  logic [XLEN-1:0]  s1_addr_r;
  logic             a_pc_r;
  logic             b_pc_r;
  logic             a_vld_r;
  logic             b_vld_r;
  logic             a_fwd_r;
  logic             b_fwd_r;
  logic [XLEN-1:0]  fwd_data_r;
  logic [RF_DEPTH-1:0] rf_vld_r;
  logic [3:0]       flags_r;
  logic             out_valid_r;
  t16ex_res_t       out_r;

  logic [3:0]       a_idx;
  logic [3:0]       b_idx;
  logic [RF_AW-1:0] raddr_a;
  logic [RF_AW-1:0] raddr_b;
  logic [XLEN-1:0]  ram_a;
  logic [XLEN-1:0]  ram_b;
  logic [XLEN-1:0]  a_val;
  logic [XLEN-1:0]  b_val;
  logic [XLEN-1:0]  pc_val;
  logic             rf_we;
  logic [RF_AW-1:0] rf_waddr;
  t16ex_res_t       alu_res;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_operation == OP_ADD_HI) begin
      a_idx = in_dest_reg;
      b_idx = in_second_reg;
    end else begin
      a_idx = {1'b0, in_dest_reg[2:0]};
      b_idx = {1'b0, in_second_reg[2:0]};
      if (in_operation == OP_ADD_REG || in_operation == OP_SUB_REG ||
          in_operation == OP_ADD_IMM || in_operation == OP_SUB_IMM) begin
        a_idx = {1'b0, in_first_reg};
      end
    end
  end

  assign raddr_a = (a_idx == PC_IDX) ? '0 : RF_AW'(a_idx);
  assign raddr_b = (b_idx == PC_IDX) ? '0 : RF_AW'(b_idx);

  assign rf_we    = s1_adv && alu_res.wrote;
  assign rf_waddr = RF_AW'(alu_res.wreg);

  t16ex_ram #(
    .WIDTH(XLEN),
    .DEPTH(RF_DEPTH)
  ) u_rf (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (rf_waddr),
    .wdata  (alu_res.value),
    .re     (accept),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(ram_a),
    .rdata_b(ram_b)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= in_operation;
      s1_dest_r   <= in_dest_reg;
      s1_second_r <= in_second_reg;
      s1_imm_r    <= in_immediate;
      s1_addr_r   <= in_instr_address;
      a_pc_r      <= (a_idx == PC_IDX);
      b_pc_r      <= (b_idx == PC_IDX);
      a_vld_r     <= rf_vld_r[raddr_a];
      b_vld_r     <= rf_vld_r[raddr_b];
      a_fwd_r     <= rf_we && (rf_waddr == raddr_a);
      b_fwd_r     <= rf_we && (rf_waddr == raddr_b);
      fwd_data_r  <= alu_res.value;
    end
    if (s1_adv) begin
      out_r <= alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
      flags_r     <= 4'd0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        flags_r     <= alu_res.nzcv;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
    end
  end

  assign pc_val = s1_addr_r + XLEN'(4);

  always_comb begin
    if (a_pc_r) a_val = pc_val;
    else if (a_fwd_r) a_val = fwd_data_r;
    else if (a_vld_r) a_val = ram_a;
    else a_val = '0;
    if (b_pc_r) b_val = pc_val;
    else if (b_fwd_r) b_val = fwd_data_r;
    else if (b_vld_r) b_val = ram_b;
    else b_val = '0;
  end

  t16ex_alu u_alu (
    .op        (s1_op_r),
    .dest_reg  (s1_dest_r),
    .second_reg(s1_second_r),
    .imm       (s1_imm_r),
    .addr      (s1_addr_r),
    .a         (a_val),
    .b         (b_val),
    .flags     (flags_r),
    .res       (alu_res)
  );

  assign out_valid            = out_valid_r;
  assign out_wrote_register   = out_r.wrote;
  assign out_written_register = out_r.wreg;
  assign out_written_value    = out_r.value;
  assign out_flags_nzcv       = out_r.nzcv;
  assign out_next_address     = out_r.next_addr;
  assign out_end_of_block     = out_r.eob;
  assign out_status           = out_r.status;

  // The program counter is never written through the register file.
  a_no_pc_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> alu_res.wreg != PC_IDX)
    else $error("register file write aimed at the program counter");

  // An instruction that is not executed leaves registers alone.
  a_no_write_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && alu_res.status != ST_OK |-> !rf_we)
    else $error("register written by an undefined or unpredictable item");

  // Flags change only when an item leaves the execute stage.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(flags_r))
    else $error("flags changed without a retiring item");

  // A finished item always reaches the output register.
  a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("retired item missing from the output");

  // Any non-executed result closes the block.
  a_fault_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.eob)
    else $error("faulting item does not end the block");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench
  import t16ex_pkg::*;
();

  localparam logic [4:0] OP_UDF      = 5'd19;
  localparam logic [4:0] OP_RSVD_TOP = 5'd31;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 60;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [4:0]  op;
    logic [3:0]  rd;
    logic [2:0]  rn;
    logic [3:0]  rm;
    logic [7:0]  imm;
    logic [31:0] addr;
  } instr_t;

  typedef struct packed {
    instr_t     it;
    logic       typed;
    t16ex_res_t want;
  } stim_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [4:0]      in_operation;
  logic [3:0]      in_dest_reg;
  logic [2:0]      in_first_reg;
  logic [3:0]      in_second_reg;
  logic [7:0]      in_immediate;
  logic [XLEN-1:0] in_instr_address;
  logic            out_valid;
  logic            out_ready;
  logic            out_wrote_register;
  logic [3:0]      out_written_register;
  logic [XLEN-1:0] out_written_value;
  logic [3:0]      out_flags_nzcv;
  logic [XLEN-1:0] out_next_address;
  logic            out_end_of_block;
  logic [1:0]      out_status;

  logic [31:0] gpr [0:RF_DEPTH-1];
  logic [3:0]  nzcv_state;
  t16ex_res_t  pending_results[$];
  stim_row_t   stim_rows[$];
  t16ex_res_t  got;
  t16ex_res_t  want;
  bit          idle_on;
  int          tick_count;
  int          mismatch_count;
  int          checked_count;
  int          items_sent;
  int          undef_count;
  int          unpred_count;
  int          pc_write_count;

  thumb16_alu_execute i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_dest_reg         (in_dest_reg),
    .in_first_reg        (in_first_reg),
    .in_second_reg       (in_second_reg),
    .in_immediate        (in_immediate),
    .in_instr_address    (in_instr_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_wrote_register  (out_wrote_register),
    .out_written_register(out_written_register),
    .out_written_value   (out_written_value),
    .out_flags_nzcv      (out_flags_nzcv),
    .out_next_address    (out_next_address),
    .out_end_of_block    (out_end_of_block),
    .out_status          (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic instr_t mk_instr(input logic [4:0] op, input logic [3:0] rd,
                                      input logic [2:0] rn, input logic [3:0] rm,
                                      input logic [7:0] imm, input logic [31:0] addr);
    instr_t it;
    it.op   = op;
    it.rd   = rd;
    it.rn   = rn;
    it.rm   = rm;
    it.imm  = imm;
    it.addr = addr;
    return it;
  endfunction

  function automatic t16ex_res_t mk_res(input logic wrote, input logic [3:0] wreg,
                                        input logic [31:0] value, input logic [3:0] nzcv,
                                        input logic [31:0] next_addr, input logic eob,
                                        input logic [1:0] status);
    t16ex_res_t r;
    r.wrote     = wrote;
    r.wreg      = wreg;
    r.value     = value;
    r.nzcv      = nzcv;
    r.next_addr = next_addr;
    r.eob       = eob;
    r.status    = status;
    return r;
  endfunction

  function automatic logic [31:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                 input logic cin, output logic cout,
                                                 output logic ovf);
    logic [32:0] sum;
    sum  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    cout = sum[32];
    ovf  = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  function automatic logic [31:0] barrel_shift(input logic [1:0] kind, input logic [31:0] x,
                                               input int unsigned amt, input logic cin,
                                               output logic cout);
    logic [31:0] res;
    int unsigned rot;
    res  = x;
    cout = cin;
    if (amt != 0) begin
      case (kind)
        SH_LSL: begin
          if (amt < 32) begin
            cout = x[32 - amt];
            res  = x << amt;
          end else begin
            cout = (amt == 32) ? x[0] : 1'b0;
            res  = '0;
          end
        end
        SH_LSR: begin
          if (amt < 32) begin
            cout = x[amt - 1];
            res  = x >> amt;
          end else begin
            cout = (amt == 32) ? x[31] : 1'b0;
            res  = '0;
          end
        end
        SH_ASR: begin
          if (amt < 32) begin
            cout = x[amt - 1];
            res  = $signed(x) >>> amt;
          end else begin
            cout = x[31];
            res  = {32{x[31]}};
          end
        end
        default: begin
          rot  = amt % 32;
          res  = (rot == 0) ? x : ((x >> rot) | (x << (32 - rot)));
          cout = res[31];
        end
      endcase
    end
    return res;
  endfunction

  function automatic logic [31:0] reg_or_pc(input logic [3:0] idx, input logic [31:0] addr);
    return (idx == PC_IDX) ? addr + 32'd4 : gpr[idx];
  endfunction

  // Executes one instruction against the model state and returns its result item.
  function automatic t16ex_res_t execute_alu_op(input instr_t it);
    t16ex_res_t  r;
    logic [2:0]  d;
    logic [2:0]  m;
    logic [31:0] rd_val;
    logic [31:0] rm_val;
    logic [31:0] rn_val;
    logic [31:0] imm32;
    logic [31:0] res;
    logic        nc;
    logic        nv;
    logic        cc;
    logic        vv;
    logic        do_write;
    logic        do_flags;
    int unsigned sa;
    int unsigned sr;
    d        = it.rd[2:0];
    m        = it.rm[2:0];
    rd_val   = gpr[{1'b0, d}];
    rm_val   = gpr[{1'b0, m}];
    rn_val   = gpr[{1'b0, it.rn}];
    imm32    = {24'd0, it.imm};
    sa       = 32'(it.imm[4:0]);
    sr       = 32'(rm_val[7:0]);
    nc       = nzcv_state[1];
    nv       = nzcv_state[0];
    res      = '0;
    do_write = 1'b1;
    do_flags = 1'b1;
    r        = '0;
    r.next_addr = it.addr + 32'd2;
    case (it.op)
      OP_LSL_IMM: res = barrel_shift(SH_LSL, rm_val, sa, nzcv_state[1], nc);
      OP_LSR_IMM: res = barrel_shift(SH_LSR, rm_val, (sa == 0) ? 32 : sa, nzcv_state[1], nc);
      OP_ASR_IMM: res = barrel_shift(SH_ASR, rm_val, (sa == 0) ? 32 : sa, nzcv_state[1], nc);
      OP_ADD_REG: res = add_with_carry(rn_val, rm_val, 1'b0, nc, nv);
      OP_SUB_REG: res = add_with_carry(rn_val, ~rm_val, 1'b1, nc, nv);
      OP_ADD_IMM: res = add_with_carry(rn_val, imm32, 1'b0, nc, nv);
      OP_SUB_IMM: res = add_with_carry(rn_val, ~imm32, 1'b1, nc, nv);
      OP_MOV_IMM: res = imm32;
      OP_CMP_IMM: begin
        res      = add_with_carry(rd_val, ~imm32, 1'b1, nc, nv);
        do_write = 1'b0;
      end
      OP_AND:     res = rd_val & rm_val;
      OP_EOR:     res = rd_val ^ rm_val;
      OP_LSL_REG: res = barrel_shift(SH_LSL, rd_val, sr, nzcv_state[1], nc);
      OP_LSR_REG: res = barrel_shift(SH_LSR, rd_val, sr, nzcv_state[1], nc);
      OP_ASR_REG: res = barrel_shift(SH_ASR, rd_val, sr, nzcv_state[1], nc);
      OP_ADC:     res = add_with_carry(rd_val, rm_val, nzcv_state[1], nc, nv);
      OP_SBC:     res = add_with_carry(rd_val, ~rm_val, nzcv_state[1], nc, nv);
      OP_ROR:     res = barrel_shift(SH_ROR, rd_val, sr, nzcv_state[1], nc);
      OP_TST: begin
        res      = rd_val & rm_val;
        do_write = 1'b0;
      end
      OP_ADD_HI: begin
        do_write = 1'b0;
        do_flags = 1'b0;
        if (it.rd == PC_IDX && it.rm == PC_IDX) begin
          r.status = ST_UNPRED;
          r.eob    = 1'b1;
        end else begin
          res = add_with_carry(reg_or_pc(it.rd, it.addr), reg_or_pc(it.rm, it.addr),
                               1'b0, cc, vv);
          if (it.rd == PC_IDX) begin
            r.wreg      = PC_IDX;
            r.next_addr = res & ~32'd1;
            r.eob       = 1'b1;
          end else begin
            gpr[it.rd] = res;
            r.wrote    = 1'b1;
            r.wreg     = it.rd;
          end
        end
      end
      default: begin
        do_write = 1'b0;
        do_flags = 1'b0;
        r.status = ST_UNDEF;
        r.eob    = 1'b1;
      end
    endcase
    if (do_write) begin
      gpr[{1'b0, d}] = res;
      r.wrote        = 1'b1;
      r.wreg         = {1'b0, d};
    end
    if (do_flags) begin
      nzcv_state = {res[31], res == 32'd0, nc, nv};
    end
    r.value = res;
    r.nzcv  = nzcv_state;
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    it.op   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                          : 5'($urandom_range(0, 18));
    it.rd   = 4'($urandom_range(0, 15));
    it.rn   = 3'($urandom_range(0, 7));
    it.rm   = 4'($urandom_range(0, 15));
    it.addr = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFC - 32'($urandom_range(0, 3))
                                           : $urandom;
    case ($urandom_range(0, 7))
      0:       it.imm = 8'h00;
      1:       it.imm = 8'hFF;
      2:       it.imm = 8'($urandom_range(0, 40));
      default: it.imm = 8'($urandom_range(0, 255));
    endcase
    if (it.op == OP_ADD_HI && $urandom_range(0, 15) == 0) begin
      it.rd = PC_IDX;
      it.rm = PC_IDX;
    end
    return it;
  endfunction

  task automatic drive_item(input instr_t it, input logic typed, input t16ex_res_t want_in);
    t16ex_res_t pred;
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap      = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_operation     = it.op;
    in_dest_reg      = it.rd;
    in_first_reg     = it.rn;
    in_second_reg    = it.rm;
    in_immediate     = it.imm;
    in_instr_address = it.addr;
    do @(posedge clk); while (!in_ready);
    pred = execute_alu_op(it);
    pending_results.push_back(typed ? want_in : pred);
    items_sent++;
    if (pred.status == ST_UNDEF) undef_count++;
    if (pred.status == ST_UNPRED) unpred_count++;
    if (pred.wreg == PC_IDX) pc_write_count++;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = {out_wrote_register, out_written_register, out_written_value, out_flags_nzcv,
             out_next_address, out_end_of_block, out_status};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected result item: %p", got);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.wrote !== want.wrote || got.wreg !== want.wreg ||
            got.value !== want.value || got.nzcv !== want.nzcv ||
            got.next_addr !== want.next_addr || got.eob !== want.eob ||
            got.status !== want.status) begin
          if (mismatch_count < 10) begin
            $display("Mismatch at result %0d: expected %p", checked_count, want);
            $display("                      actual   %p", got);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    tick_count <= tick_count + 1;
    if (tick_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = '0;
    in_dest_reg      = '0;
    in_first_reg     = '0;
    in_second_reg    = '0;
    in_immediate     = '0;
    in_instr_address = '0;
    idle_on          = 1'b1;
    tick_count       = 0;
    mismatch_count   = 0;
    checked_count    = 0;
    items_sent       = 0;
    undef_count      = 0;
    unpred_count     = 0;
    pc_write_count   = 0;
    nzcv_state       = '0;
    foreach (gpr[i]) gpr[i] = '0;

    stim_rows.push_back('{mk_instr(OP_UDF, 4'd0, 3'd0, 4'd0, 8'd0, 32'hFFFF_FFFE), 1'b1,
                          mk_res(1'b0, 4'd0, 32'd0, 4'b0000, 32'h0, 1'b1, ST_UNDEF)});
    stim_rows.push_back('{mk_instr(OP_RSVD_TOP, 4'd5, 3'd2, 4'd7, 8'd9, 32'h100), 1'b1,
                          mk_res(1'b0, 4'd0, 32'd0, 4'b0000, 32'h102, 1'b1, ST_UNDEF)});
    stim_rows.push_back('{mk_instr(OP_ADD_HI, PC_IDX, 3'd0, PC_IDX, 8'd0, 32'h200), 1'b1,
                          mk_res(1'b0, 4'd0, 32'd0, 4'b0000, 32'h202, 1'b1, ST_UNPRED)});
    stim_rows.push_back('{mk_instr(OP_MOV_IMM, 4'd9, 3'd0, 4'd0, 8'h00, 32'h1000), 1'b1,
                          mk_res(1'b1, 4'd1, 32'd0, 4'b0100, 32'h1002, 1'b0, ST_OK)});
    stim_rows.push_back('{mk_instr(OP_MOV_IMM, 4'd0, 3'd0, 4'd0, 8'hFF, 32'h1002), 1'b1,
                          mk_res(1'b1, 4'd0, 32'hFF, 4'b0000, 32'h1004, 1'b0, ST_OK)});
    stim_rows.push_back('{mk_instr(OP_LSL_IMM, 4'd2, 3'd0, 4'd0, 8'hFF, 32'h1004), 1'b1,
                          mk_res(1'b1, 4'd2, 32'h8000_0000, 4'b1010, 32'h1006, 1'b0, ST_OK)});
    stim_rows.push_back('{mk_instr(OP_LSR_IMM, 4'd3, 3'd0, 4'd10, 8'hE0, 32'h1006), 1'b1,
                          mk_res(1'b1, 4'd3, 32'd0, 4'b0110, 32'h1008, 1'b0, ST_OK)});
    stim_rows.push_back('{mk_instr(OP_ASR_IMM, 4'd4, 3'd0, 4'd2, 8'h00, 32'h1008), 1'b1,
                          mk_res(1'b1, 4'd4, 32'hFFFF_FFFF, 4'b1010, 32'h100A, 1'b0, ST_OK)});
    stim_rows.push_back('{mk_instr(OP_ADD_REG, 4'd5, 3'd4, 4'd4, 8'd0, 32'h2000), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_SUB_REG, 4'd6, 3'd5, 4'd5, 8'd0, 32'h2002), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_ADD_IMM, 4'd7, 3'd4, 4'd0, 8'hFF, 32'h2004), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_SUB_IMM, 4'd1, 3'd1, 4'd0, 8'hFF, 32'h2006), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_MOV_IMM, 4'd6, 3'd0, 4'd0, 8'd32, 32'h2008), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_CMP_IMM, 4'd6, 3'd0, 4'd0, 8'd32, 32'h200A), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_LSL_REG, 4'd0, 3'd0, 4'd6, 8'd0, 32'h200C), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_MOV_IMM, 4'd7, 3'd0, 4'd0, 8'd33, 32'h200E), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_LSR_REG, 4'd4, 3'd0, 4'd7, 8'd0, 32'h2010), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_ASR_REG, 4'd5, 3'd0, 4'd6, 8'd0, 32'h2012), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_ROR, 4'd1, 3'd0, 4'd6, 8'd0, 32'h2014), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_LSL_REG, 4'd1, 3'd0, 4'd3, 8'd0, 32'h2016), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_ADC, 4'd5, 3'd0, 4'd1, 8'd0, 32'h2018), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_SBC, 4'd1, 3'd0, 4'd5, 8'd0, 32'h201A), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_AND, 4'd2, 3'd0, 4'd5, 8'd0, 32'h201C), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_EOR, 4'd5, 3'd0, 4'd1, 8'd0, 32'h201E), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_TST, 4'd5, 3'd0, 4'd1, 8'd0, 32'h2020), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_ADD_HI, 4'd8, 3'd0, PC_IDX, 8'd0, 32'h7FFF_FFFE), 1'b0,
                          '0});
    stim_rows.push_back('{mk_instr(OP_ADD_HI, 4'd14, 3'd0, 4'd8, 8'd0, 32'h2024), 1'b0, '0});
    stim_rows.push_back('{mk_instr(OP_ADD_HI, PC_IDX, 3'd0, 4'd3, 8'd0, 32'h3000), 1'b0, '0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      drive_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      drive_item(random_instr(), 1'b0, '0);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions (%0d from the directed table), %0d results checked.",
             items_sent, stim_rows.size(), checked_count);
    $display("Seen %0d undefined, %0d unpredictable and %0d PC-writing instructions.",
             undef_count, unpred_count, pc_write_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
